@@ rtl/core/lms_pkg.sv @@
package lms_pkg;

    // fixed widths of the item fields
    localparam int SAMPLE_W  = 32;
    localparam int OUT_LEN_W = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIES_OK    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECREASING = 2'd1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       first;
    } t_in_item;

    typedef struct packed {
        logic [OUT_LEN_W-1:0] length_here;
        logic [OUT_LEN_W-1:0] best_so_far;
        logic                 overflow;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CMP,
        ST_WRITE,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic lo_lt_hi;
        logic out_free;
    } t_sts;

endpackage

@@ rtl/core/lms_ram.sv @@
module lms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/lms_ctrl.sv @@
module lms_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  lms_pkg::t_sts i_sts,
    output lms_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);

    lms_pkg::t_state r_state;
    lms_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lms_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            lms_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = lms_pkg::ST_SEARCH;
                end
            end
            lms_pkg::ST_SEARCH: begin
                // probe address goes to the ram this cycle
                n_state = i_sts.lo_lt_hi ? lms_pkg::ST_CMP : lms_pkg::ST_WRITE;
            end
            lms_pkg::ST_CMP: begin
                o_cmd.step = 1'b1;
                n_state    = lms_pkg::ST_SEARCH;
            end
            lms_pkg::ST_WRITE: begin
                o_cmd.finish = 1'b1;
                n_state      = lms_pkg::ST_DONE;
            end
            lms_pkg::ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = lms_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lms_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/lms_dp.sv @@
module lms_dp #(
    parameter int MAX_LEN     = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  lms_pkg::t_in_item                i_in_item,
    input  logic                             i_cfg_we,
    input  logic [lms_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lms_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    input  lms_pkg::t_cmd                    i_cmd,
    output lms_pkg::t_sts                    o_sts,
    input  logic                             i_out_stall,
    output logic                             o_out_valid,
    output lms_pkg::t_out_item               o_out_item
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int FW = $clog2(MAX_LEN + 1);
    localparam logic [FW-1:0] MAX_CNT = FW'(MAX_LEN);
    localparam logic [VALUE_WIDTH-1:0] SIGN_BIT = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    logic                   r_ties_ok;
    logic                   r_decreasing;
    logic [FW-1:0]          r_fill;
    logic [FW-1:0]          r_best;
    logic [FW-1:0]          r_lo;
    logic [FW-1:0]          r_hi;
    logic [VALUE_WIDTH-1:0] r_val;
    logic [FW-1:0]          r_len;
    logic                   r_ovf;
    logic                   r_out_valid;
    lms_pkg::t_out_item     r_out_item;

    logic [FW-1:0]          mid;
    logic [FW-1:0]          fill_start;
    logic [VALUE_WIDTH-1:0] tail_rd;
    logic [VALUE_WIDTH-1:0] key_tail;
    logic [VALUE_WIDTH-1:0] key_val;
    logic                   go_right;
    logic                   we;
    logic [FW-1:0]          len_new;
    logic                   ovf_new;
    logic                   append;

    assign mid        = r_lo + ((r_hi - r_lo) >> 1);
    assign fill_start = i_in_item.first ? '0 : r_fill;

    lms_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (MAX_LEN)
    ) u_tails (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_lo[AW-1:0]),
        .i_wdata (r_val),
        .i_raddr (mid[AW-1:0]),
        .o_rdata (tail_rd)
    );

    // order keys: flip the sign bit, invert all for decreasing order
    always_comb begin
        key_tail = tail_rd ^ SIGN_BIT;
        key_val  = r_val ^ SIGN_BIT;
        if (r_decreasing) begin
            key_tail = ~key_tail;
            key_val  = ~key_val;
        end
        go_right = r_ties_ok ? (key_tail <= key_val) : (key_tail < key_val);
    end

    // replace, append or drop at the found position
    always_comb begin
        append  = (r_lo == r_fill);
        ovf_new = append && (r_fill == MAX_CNT);
        we      = i_cmd.finish && !ovf_new;
        len_new = ovf_new ? MAX_CNT : r_lo + FW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ties_ok    <= 1'b0;
            r_decreasing <= 1'b0;
            r_fill       <= '0;
            r_best       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == lms_pkg::CFG_TIES_OK) begin
                    r_ties_ok <= i_cfg_data[0];
                end
                if (i_cfg_index == lms_pkg::CFG_DECREASING) begin
                    r_decreasing <= i_cfg_data[0];
                end
            end
            if (i_cmd.load && i_in_item.first) begin
                r_fill <= '0;
                r_best <= '0;
            end
            if (i_cmd.finish) begin
                if (append && !ovf_new) begin
                    r_fill <= r_fill + FW'(1);
                end
                if (len_new > r_best) begin
                    r_best <= len_new;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val <= VALUE_WIDTH'(i_in_item.sample);
            r_lo  <= '0;
            r_hi  <= fill_start;
        end else if (i_cmd.step) begin
            if (go_right) begin
                r_lo <= mid + FW'(1);
            end else begin
                r_hi <= mid;
            end
        end
        if (i_cmd.finish) begin
            r_len <= len_new;
            r_ovf <= ovf_new;
        end
        if (i_cmd.out_load) begin
            r_out_item.length_here <= lms_pkg::OUT_LEN_W'(r_len);
            r_out_item.best_so_far <= lms_pkg::OUT_LEN_W'(r_best);
            r_out_item.overflow    <= r_ovf;
        end
    end

    assign o_sts.lo_lt_hi = (r_lo < r_hi);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_out_item     = r_out_item;

endmodule

@@ rtl/core/longest_monotone_subsequence.sv @@
// longest monotone subsequence, streaming patience-sort form
// input channel: i_in_valid / o_in_stall carry one item (sample, first);
//   first = 1 empties the tails store and the best length before the sample
// output channel: o_out_valid / i_out_stall carry one item per input item
//   (length_here, best_so_far, overflow), in input order
// config channel: i_cfg_valid / o_cfg_ready with index 0 = equal values
//   extend a run (non-strict), index 1 = decreasing; ready is always high,
//   other indexes are ignored
// timing: one item is worked on at a time; a binary search over the tails
//   ram makes each probe as an address state, then a compare on the
//   registered read data, with P = number of probes <= clog2(fill + 1);
//   the item then passes a write-back state and a hand-off state;
//   over the whole store P <= clog2(MAX_LEN + 1)
// a finished item sits in the output register, so the next item is taken
//   while the receiver stalls; only a second finished item then waits
// reset (synchronous, active low) empties the store, zeroes best length
//   and config, and drops any pending output item; the tails ram is not
//   cleared since only entries below the fill count are ever read
module longest_monotone_subsequence #(
    parameter int MAX_LEN     = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input items
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  lms_pkg::t_in_item             i_in_item,
    // result items
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output lms_pkg::t_out_item            o_out_item,
    // config writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lms_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lms_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    lms_pkg::t_cmd cmd;
    lms_pkg::t_sts sts;

    // config is always taken; the user must change it only while no item is in flight, the block does not enforce this
    assign o_cfg_ready = 1'b1;

    // sequencer: idle, probe, compare, write back, hand off
    lms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // search bounds, tails ram, fill count, best length, output register
    lms_dp #(
        .MAX_LEN     (MAX_LEN),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

@@ rtl/core/lms_checker.sv @@
module lms_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input lms_pkg::t_out_item o_out_item
);

    // at most one item in the search at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while a search is running");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result item changed");

    // a dropped append reports the full length, which is also the best
    a_ovf_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.overflow) |->
            (o_out_item.length_here == o_out_item.best_so_far))
        else $error("overflow item with length below best");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("reset left output valid or input stalled");

endmodule

bind longest_monotone_subsequence lms_checker u_lms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
